// File: src/i2c_bus_master_core_defines.svh
// Assertion macros used by the I2C master checker.
`ifndef I2C_BUS_MASTER_CORE_DEFINES_SVH
`define I2C_BUS_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define I2CM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: src/i2cm_pkg.sv
// Shared types and constants of the I2C bus master.
package i2cm_pkg;

    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 1;
    localparam int ACT_W     = 3;
    localparam int BYTE_W    = 8;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_PHASE_TICKS = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACK_POLLS   = 1'd1;

    localparam logic [CFG_W-1:0] PHASE_TICKS_RST = 16'd100;
    localparam logic [CFG_W-1:0] ACK_POLLS_RST   = 16'd256;

    // Command codes
    localparam logic [ACT_W-1:0] ACT_START = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ACK   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_NACK  = 3'd6;

    typedef struct packed {
        logic [CFG_W-1:0] phase_ticks;
        logic [CFG_W-1:0] ack_polls;
    } cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic              sda_line;
        logic              scl_line;
    } item_t;

    typedef struct packed {
        logic              scl_drive_low;
        logic              sda_drive_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              error;
    } res_t;

endpackage

// File: src/i2cm_cfg_regs.sv
// Configuration registers of the I2C bus master.
module i2cm_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [i2cm_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  logic [i2cm_pkg::CFG_W-1:0]      cfg_wdata,
    output i2cm_pkg::cfg_t                  cfg
);
    import i2cm_pkg::*;

    cfg_t cfg_reg;

    // Register write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks <= PHASE_TICKS_RST;
            cfg_reg.ack_polls   <= ACK_POLLS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_wdata;
                REG_ACK_POLLS:   cfg_reg.ack_polls   <= cfg_wdata;
                default:         cfg_reg.ack_polls   <= cfg_reg.ack_polls;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/i2cm_seq.sv
// Bus sequencer: one tick of the I2C master per step.
module i2cm_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  i2cm_pkg::item_t item,
    input  i2cm_pkg::cfg_t  cfg,
    output i2cm_pkg::res_t  res_next
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'd0,
        ST_ST_SDA_REL = 5'd1,
        ST_ST_SCL_REL = 5'd2,
        ST_ST_SDA_LOW = 5'd3,
        ST_SP_SDA_LOW = 5'd4,
        ST_SP_SCL_REL = 5'd5,
        ST_WAIT_DONE  = 5'd6,
        ST_WR_DATA    = 5'd7,
        ST_WR_SCL_HI  = 5'd8,
        ST_WR_SCL_LO  = 5'd9,
        ST_WR_ACK_SDA = 5'd10,
        ST_WR_ACK_SCL = 5'd11,
        ST_WR_POLL    = 5'd12,
        ST_RD_WAIT    = 5'd13,
        ST_RD_SCL_HI  = 5'd14,
        ST_AK_SDA     = 5'd15,
        ST_AK_SCL_HI  = 5'd16
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [3:0]        bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [CFG_W-1:0]  timer_reg, timer_next;
    logic [CFG_W-1:0]  poll_reg, poll_next;
    logic              error_reg, error_next;
    logic              scl_low_reg, scl_low_next;
    logic              sda_low_reg, sda_low_next;
    logic [BYTE_W-1:0] read_reg, read_next;
    logic              done;

    logic [CFG_W-1:0]  wait_ticks;
    logic [CFG_W-1:0]  poll_init;
    logic [CFG_W-1:0]  poll_src;
    logic [CFG_W-1:0]  poll_dec;
    logic              ack_seen;
    logic [3:0]        idx_inc;
    logic [BYTE_W-1:0] wr_shift;
    logic [BYTE_W-1:0] rd_shift;

    // Zero settings count as one
    assign wait_ticks = (cfg.phase_ticks == '0) ? CFG_W'(1) : cfg.phase_ticks;
    assign poll_init  = (cfg.ack_polls == '0) ? CFG_W'(1) : cfg.ack_polls;

    // ACK poll: first sample loads the count, later ones use the register
    assign poll_src = (state_reg == ST_WR_POLL) ? poll_reg : poll_init;
    assign poll_dec = (poll_src != '0) ? poll_src - CFG_W'(1) : '0;
    assign ack_seen = !item.sda_line;

    assign idx_inc  = bit_index_reg + 4'd1;
    assign wr_shift = {shift_reg[BYTE_W-2:0], 1'b0};
    assign rd_shift = {shift_reg[BYTE_W-2:0], item.sda_line};

    // Next-state logic for one tick
    always_comb begin
        state_next     = state_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        timer_next     = timer_reg;
        poll_next      = poll_reg;
        error_next     = error_reg;
        scl_low_next   = scl_low_reg;
        sda_low_next   = sda_low_reg;
        read_next      = read_reg;
        done           = 1'b0;

        if (state_reg == ST_IDLE) begin
            // Command decode; other codes are a plain tick
            case (item.action)
                ACT_START: begin
                    error_next   = 1'b0;
                    sda_low_next = 1'b0;
                    state_next   = ST_ST_SDA_REL;
                    timer_next   = wait_ticks;
                end
                ACT_STOP: begin
                    sda_low_next = 1'b1;
                    state_next   = ST_SP_SDA_LOW;
                    timer_next   = wait_ticks;
                end
                ACT_WRITE: begin
                    shift_next     = item.data_byte;
                    bit_index_next = 4'd0;
                    sda_low_next   = !item.data_byte[BYTE_W-1];
                    state_next     = ST_WR_DATA;
                    timer_next     = wait_ticks;
                end
                ACT_READ: begin
                    sda_low_next   = 1'b0;
                    shift_next     = '0;
                    bit_index_next = 4'd0;
                    state_next     = ST_RD_WAIT;
                    timer_next     = wait_ticks;
                end
                ACT_ACK, ACT_NACK: begin
                    sda_low_next = (item.action == ACT_ACK);
                    state_next   = ST_AK_SDA;
                    timer_next   = wait_ticks;
                end
                default: ;
            endcase
        end else if (state_reg == ST_WR_POLL) begin
            if (ack_seen) begin
                error_next   = 1'b0;
                scl_low_next = 1'b1;
                state_next   = ST_IDLE;
                timer_next   = '0;
                done         = 1'b1;
            end else begin
                poll_next = poll_dec;
                if (poll_dec == '0) begin
                    scl_low_next = 1'b1;
                    state_next   = ST_IDLE;
                    timer_next   = '0;
                    done         = 1'b1;
                end
            end
        end else if (timer_reg > CFG_W'(1)) begin
            timer_next = timer_reg - CFG_W'(1);
        end else begin
            // End of a bus phase
            timer_next = wait_ticks;
            unique case (state_reg)
                ST_ST_SDA_REL: begin
                    scl_low_next = 1'b0;
                    state_next   = ST_ST_SCL_REL;
                end
                ST_ST_SCL_REL: begin
                    if (item.sda_line && item.scl_line) begin
                        sda_low_next = 1'b1;
                        state_next   = ST_ST_SDA_LOW;
                    end else begin
                        // bus busy: flag and give up
                        error_next = 1'b1;
                        state_next = ST_IDLE;
                        timer_next = '0;
                        done       = 1'b1;
                    end
                end
                ST_ST_SDA_LOW: begin
                    scl_low_next = 1'b1;
                    state_next   = ST_WAIT_DONE;
                end
                ST_SP_SDA_LOW: begin
                    scl_low_next = 1'b0;
                    state_next   = ST_SP_SCL_REL;
                end
                ST_SP_SCL_REL: begin
                    sda_low_next = 1'b0;
                    state_next   = ST_WAIT_DONE;
                end
                ST_WR_DATA: begin
                    scl_low_next = 1'b0;
                    state_next   = ST_WR_SCL_HI;
                end
                ST_WR_SCL_HI: begin
                    scl_low_next = 1'b1;
                    state_next   = ST_WR_SCL_LO;
                end
                ST_WR_SCL_LO: begin
                    shift_next     = wr_shift;
                    bit_index_next = idx_inc;
                    if (idx_inc < 4'd8) begin
                        sda_low_next = !wr_shift[BYTE_W-1];
                        state_next   = ST_WR_DATA;
                    end else begin
                        sda_low_next = 1'b0;
                        state_next   = ST_WR_ACK_SDA;
                    end
                end
                ST_WR_ACK_SDA: begin
                    scl_low_next = 1'b0;
                    state_next   = ST_WR_ACK_SCL;
                end
                ST_WR_ACK_SCL: begin
                    // first ACK sample on the same tick
                    timer_next = '0;
                    poll_next  = poll_init;
                    if (ack_seen) begin
                        error_next   = 1'b0;
                        scl_low_next = 1'b1;
                        state_next   = ST_IDLE;
                        done         = 1'b1;
                    end else begin
                        error_next = 1'b1;
                        poll_next  = poll_dec;
                        state_next = ST_WR_POLL;
                        if (poll_dec == '0) begin
                            scl_low_next = 1'b1;
                            state_next   = ST_IDLE;
                            done         = 1'b1;
                        end
                    end
                end
                ST_RD_WAIT: begin
                    scl_low_next = 1'b0;
                    state_next   = ST_RD_SCL_HI;
                end
                ST_RD_SCL_HI: begin
                    shift_next     = rd_shift;
                    bit_index_next = idx_inc;
                    scl_low_next   = 1'b1;
                    if (idx_inc < 4'd8) begin
                        state_next = ST_RD_WAIT;
                    end else begin
                        read_next  = rd_shift;
                        state_next = ST_IDLE;
                        timer_next = '0;
                        done       = 1'b1;
                    end
                end
                ST_AK_SDA: begin
                    scl_low_next = 1'b0;
                    state_next   = ST_AK_SCL_HI;
                end
                ST_AK_SCL_HI: begin
                    scl_low_next = 1'b1;
                    state_next   = ST_WAIT_DONE;
                end
                default: begin
                    // wait-done and unused codes end the command
                    state_next = ST_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
            endcase
        end
    end

    // State registers, advanced once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            timer_reg     <= '0;
            poll_reg      <= '0;
            error_reg     <= 1'b0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
            read_reg      <= '0;
        end else if (step_en) begin
            state_reg     <= state_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            timer_reg     <= timer_next;
            poll_reg      <= poll_next;
            error_reg     <= error_next;
            scl_low_reg   <= scl_low_next;
            sda_low_reg   <= sda_low_next;
            read_reg      <= read_next;
        end
    end

    // Result of this tick
    assign res_next.scl_drive_low = scl_low_next;
    assign res_next.sda_drive_low = sda_low_next;
    assign res_next.busy_res      = (state_next != ST_IDLE);
    assign res_next.done_res      = done;
    assign res_next.read_data     = read_next;
    assign res_next.error         = error_next;

endmodule

// File: src/i2c_bus_master_core.sv
// I2C bus master top level: input register, sequencer, result register.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready | action, data_byte, sda_line, scl_line
//  m_      | out       | m_valid / m_ready | scl/sda drive, busy, done, read_data, error
//  cfg_    | in        | cfg_we            | cfg_addr, cfg_wdata (no read-back)
//
// One item per cycle; each item is one bus tick of the sequencer.
// Each item passes the input register, then its result the result register.
// The sequencer steps only when the result register is free or being taken,
// so a stalled m_ready holds both stages and then drops s_ready.
// Synchronous active-low reset; no clearing pass.
module i2c_bus_master_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [i2cm_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  logic [i2cm_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [i2cm_pkg::ACT_W-1:0]      s_action,
    input  logic [i2cm_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                            s_sda_line,
    input  logic                            s_scl_line,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_scl_drive_low,
    output logic                            m_sda_drive_low,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic [i2cm_pkg::BYTE_W-1:0]     m_read_data,
    output logic                            m_error
);
    import i2cm_pkg::*;

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res_next;
    res_t  out_res_reg;
    logic  out_valid_reg;
    logic  step;
    logic  in_take;

    i2cm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Pipeline control
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign in_take = s_valid && s_ready;

    i2cm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step),
        .item     (in_item_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_take || (in_valid_reg && !step);
            out_valid_reg <= step || (out_valid_reg && !m_ready);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.action    <= s_action;
            in_item_reg.data_byte <= s_data_byte;
            in_item_reg.sda_line  <= s_sda_line;
            in_item_reg.scl_line  <= s_scl_line;
        end
        if (step) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_scl_drive_low = out_res_reg.scl_drive_low;
    assign m_sda_drive_low = out_res_reg.sda_drive_low;
    assign m_busy_res      = out_res_reg.busy_res;
    assign m_done_res      = out_res_reg.done_res;
    assign m_read_data     = out_res_reg.read_data;
    assign m_error         = out_res_reg.error;

endmodule

// File: src/i2cm_checker.sv
// Port-level checker for the I2C bus master, bound to the top level.
`include "i2c_bus_master_core_defines.svh"

module i2cm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_scl_drive_low,
    input logic                            m_sda_drive_low,
    input logic                            m_busy_res,
    input logic                            m_done_res,
    input logic [i2cm_pkg::BYTE_W-1:0]     m_read_data,
    input logic                            m_error
);

    logic [i2cm_pkg::BYTE_W+4:0] res_bits;

    // Whole result payload, for the hold check
    assign res_bits = {m_scl_drive_low, m_sda_drive_low, m_busy_res, m_done_res,
                       m_read_data, m_error};

    // A held result keeps its payload
    `I2CM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(res_bits))

    // A finishing command leaves the sequencer idle
    `I2CM_ASSERT_NOW(a_done_idle, aclk, aresetn, m_valid && m_done_res, !m_busy_res)

    // Input backpressure only when the result register is full and stalled
    `I2CM_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)

endmodule

bind i2c_bus_master_core i2cm_checker u_i2cm_checker (.*);
